// File: hw/rtl/lrast_pkg.sv
`default_nettype none

package lrast_pkg;

  // Fixed widths of the framebuffer side
  localparam int OFF_W       = 28;
  localparam int STRIDE_W    = 16;
  localparam int PIXEL_SHIFT = 2;   // 4 bytes per pixel

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd5504;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Octant classes after endpoint ordering along the major axis
  typedef enum logic [1:0] {
    CLS_SHALLOW_FALL = 2'd0,
    CLS_SHALLOW_RISE = 2'd1,
    CLS_STEEP_RIGHT  = 2'd2,
    CLS_STEEP_LEFT   = 2'd3
  } line_class_t;

  // Status from the back end toward the top level
  typedef struct packed {
    logic pop;
    logic active;
  } bk_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/lrast_fifo.sv
`default_nettype none

module lrast_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lrast_front.sv
`default_nettype none

module lrast_front
  import lrast_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 1 + 3 * COORD_BITS + 2 + (COORD_BITS + 4)
                             + 2 * (COORD_BITS + 2) + OFF_W
) (
  input  wire logic                  command,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [STRIDE_W-1:0]   row_stride,
  output logic      [ENTRY_W-1:0]    entry
);

  localparam int C       = COORD_BITS;
  localparam int DEC_W   = C + 4;
  localparam int DELTA_W = C + 2;
  localparam int PROD_W  = C + STRIDE_W;

  typedef struct packed {
    logic                      cmd;
    logic [C-1:0]              x0;
    logic [C-1:0]              y0;
    logic [C-1:0]              major_end;
    line_class_t               cls;
    logic signed [DEC_W-1:0]   dec;
    logic signed [DELTA_W-1:0] a2;
    logic signed [DELTA_W-1:0] b2;
    logic [OFF_W-1:0]          row_part;
  } entry_t;

  entry_t             ent;
  logic signed [C:0]  dx, dy, a, b;
  logic [C:0]         adx, ady;
  logic               shallow, swap;
  logic [C-1:0]       ox0, oy0, ox1, oy1;
  logic [DEC_W-1:0]   a_e, b_e;
  logic [PROD_W-1:0]  prod_s, prod_e;

  assign dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
  assign adx = dx[C] ? -dx : dx;
  assign ady = dy[C] ? -dy : dy;

  // Ties on the span go to the steep side
  assign shallow = (adx > ady);
  assign swap    = shallow ? (start_x > end_x) : (start_y > end_y);

  assign ox0 = swap ? end_x : start_x;
  assign oy0 = swap ? end_y : start_y;
  assign ox1 = swap ? start_x : end_x;
  assign oy1 = swap ? start_y : end_y;

  assign a   = $signed({1'b0, oy0}) - $signed({1'b0, oy1});
  assign b   = $signed({1'b0, ox1}) - $signed({1'b0, ox0});
  assign a_e = {{(DEC_W - C - 1){a[C]}}, a};
  assign b_e = {{(DEC_W - C - 1){b[C]}}, b};

  // Both row products run beside the classifier; the ordering picks one
  assign prod_s = PROD_W'(start_y) * PROD_W'(row_stride);
  assign prod_e = PROD_W'(end_y) * PROD_W'(row_stride);

  always_comb begin
    ent           = '0;
    ent.cmd       = (command == CMD_START) ? CMD_START : CMD_STEP;
    ent.x0        = ox0;
    ent.y0        = oy0;
    ent.major_end = shallow ? ox1 : oy1;
    ent.a2        = {a, 1'b0};
    ent.b2        = {b, 1'b0};
    ent.row_part  = OFF_W'(swap ? prod_e : prod_s);
    if (shallow) begin
      ent.cls = (oy0 > oy1) ? CLS_SHALLOW_FALL : CLS_SHALLOW_RISE;
    end else begin
      ent.cls = (ox1 > ox0) ? CLS_STEEP_RIGHT : CLS_STEEP_LEFT;
    end
    case (ent.cls)
      CLS_SHALLOW_FALL: ent.dec = (a_e <<< 1) - b_e;
      CLS_SHALLOW_RISE: ent.dec = (a_e <<< 1) + b_e;
      CLS_STEEP_RIGHT:  ent.dec = a_e + (b_e <<< 1);
      default:          ent.dec = (b_e <<< 1) - a_e;
    endcase
  end

  assign entry = ent;

endmodule

`default_nettype wire

// File: hw/rtl/lrast_back.sv
`default_nettype none

module lrast_back
  import lrast_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_W    = 1 + 3 * COORD_BITS + 2 + (COORD_BITS + 4)
                             + 2 * (COORD_BITS + 2) + OFF_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [ENTRY_W-1:0]    q_data,
  input  wire logic                  q_empty,
  input  wire logic [STRIDE_W-1:0]   row_stride,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output logic      [OFF_W-1:0]      byte_offset,
  output logic                       last_pixel,
  output bk_stat_t                   stat
);

  localparam int C       = COORD_BITS;
  localparam int DEC_W   = C + 4;
  localparam int DELTA_W = C + 2;

  typedef struct packed {
    logic                      cmd;
    logic [C-1:0]              x0;
    logic [C-1:0]              y0;
    logic [C-1:0]              major_end;
    line_class_t               cls;
    logic signed [DEC_W-1:0]   dec;
    logic signed [DELTA_W-1:0] a2;
    logic signed [DELTA_W-1:0] b2;
    logic [OFF_W-1:0]          row_part;
  } entry_t;

  entry_t                    ent;
  logic [C-1:0]              cur_x_r, cur_x_nxt;
  logic [C-1:0]              cur_y_r, cur_y_nxt;
  logic [C-1:0]              major_end_r, major_end_nxt;
  logic signed [DEC_W-1:0]   dec_r, dec_nxt;
  logic signed [DELTA_W-1:0] a2_r, a2_nxt;
  logic signed [DELTA_W-1:0] b2_r, b2_nxt;
  line_class_t               cls_r, cls_nxt;
  logic [OFF_W-1:0]          off_r, off_nxt;
  logic                      active_r, active_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic                      pop, is_step;
  logic                      shallow, mv, minor_neg, dec_pos, dec_neg;
  logic [C-1:0]              mv_c, major_new;
  logic [DEC_W-1:0]          a2_e, b2_e;
  logic [OFF_W-1:0]          pix_step, stride_e, minor_amt, major_amt;

  assign ent      = entry_t'(q_data);
  assign is_step  = (ent.cmd == CMD_STEP);
  assign pop      = !q_empty && (!out_valid_r || !out_stall);

  assign a2_e     = {{(DEC_W - DELTA_W){a2_r[DELTA_W-1]}}, a2_r};
  assign b2_e     = {{(DEC_W - DELTA_W){b2_r[DELTA_W-1]}}, b2_r};
  assign dec_neg  = dec_r[DEC_W-1];
  assign dec_pos  = !dec_r[DEC_W-1] && (dec_r != '0);
  assign pix_step = OFF_W'(1) << PIXEL_SHIFT;
  assign stride_e = OFF_W'(row_stride);
  assign shallow  = (cls_r == CLS_SHALLOW_FALL) || (cls_r == CLS_SHALLOW_RISE);
  assign mv_c     = {{(C - 1){1'b0}}, mv};

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    dec_nxt       = dec_r;
    a2_nxt        = a2_r;
    b2_nxt        = b2_r;
    cls_nxt       = cls_r;
    off_nxt       = off_r;
    active_nxt    = active_r;
    mv            = 1'b0;
    minor_neg     = 1'b0;
    minor_amt     = '0;
    major_amt     = '0;
    major_new     = '0;

    if (!is_step) begin
      // Load a new line; any line in flight is dropped
      cur_x_nxt     = ent.x0;
      cur_y_nxt     = ent.y0;
      major_end_nxt = ent.major_end;
      dec_nxt       = ent.dec;
      a2_nxt        = ent.a2;
      b2_nxt        = ent.b2;
      cls_nxt       = ent.cls;
      off_nxt       = (OFF_W'(ent.x0) << PIXEL_SHIFT) + ent.row_part;
      major_new     = ((ent.cls == CLS_SHALLOW_FALL) || (ent.cls == CLS_SHALLOW_RISE)) ?
                      ent.x0 : ent.y0;
      active_nxt    = (major_new != ent.major_end);
    end else if (active_r) begin
      case (cls_r)
        CLS_SHALLOW_FALL: begin
          mv        = dec_pos;
          dec_nxt   = dec_r + a2_e - (mv ? b2_e : '0);
          cur_x_nxt = cur_x_r + 1'b1;
          cur_y_nxt = cur_y_r - mv_c;
          minor_neg = 1'b1;
        end
        CLS_SHALLOW_RISE: begin
          mv        = dec_neg;
          dec_nxt   = dec_r + a2_e + (mv ? b2_e : '0);
          cur_x_nxt = cur_x_r + 1'b1;
          cur_y_nxt = cur_y_r + mv_c;
        end
        CLS_STEEP_RIGHT: begin
          mv        = dec_pos;
          dec_nxt   = dec_r + b2_e + (mv ? a2_e : '0);
          cur_x_nxt = cur_x_r + mv_c;
          cur_y_nxt = cur_y_r + 1'b1;
        end
        default: begin
          mv        = dec_neg;
          dec_nxt   = dec_r + b2_e - (mv ? a2_e : '0);
          cur_x_nxt = cur_x_r - mv_c;
          cur_y_nxt = cur_y_r + 1'b1;
          minor_neg = 1'b1;
        end
      endcase
      major_amt  = shallow ? pix_step : stride_e;
      minor_amt  = mv ? (shallow ? stride_e : pix_step) : '0;
      off_nxt    = off_r + major_amt + (minor_neg ? (OFF_W'(0) - minor_amt) : minor_amt);
      major_new  = shallow ? cur_x_nxt : cur_y_nxt;
      active_nxt = (major_new != major_end_r);
    end

    if (pop) begin
      out_valid_nxt = !is_step || active_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      major_end_r <= '0;
      dec_r       <= '0;
      a2_r        <= '0;
      b2_r        <= '0;
      cls_r       <= CLS_SHALLOW_FALL;
      off_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        major_end_r <= major_end_nxt;
        dec_r       <= dec_nxt;
        a2_r        <= a2_nxt;
        b2_r        <= b2_nxt;
        cls_r       <= cls_nxt;
        off_r       <= off_nxt;
        active_r    <= active_nxt;
      end
    end
  end

  // The line state doubles as the output register: it only moves on a pop,
  // and a pop only happens when the previous pixel has left
  assign out_valid   = out_valid_r;
  assign pixel_x     = cur_x_r;
  assign pixel_y     = cur_y_r;
  assign byte_offset = off_r;
  assign last_pixel  = !active_r;
  assign stat.pop    = pop;
  assign stat.active = active_r;

endmodule

`default_nettype wire

// File: hw/rtl/midpoint_line_rasterizer_unit.sv
// Path: a command is stored in the command queue and then registered in the
//   pixel engine state; an output stall can hold it in the queue.
// Throughput: one command per clock unless the queue is full; one pixel per
//   active step without output stall, via the single decision/offset update.
// Reset (rst_n low, synchronous): empties the queue, drops any line, clears
//   the output valid and loads row_stride with 5504.
`default_nettype none

module midpoint_line_rasterizer_unit
  import lrast_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_command,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  // pixel channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [COORD_BITS-1:0] out_pixel_x,
  output logic      [COORD_BITS-1:0] out_pixel_y,
  output logic      [OFF_W-1:0]      out_byte_offset,
  output logic                       out_last_pixel,
  // row stride register
  input  wire logic                  cfg_we,
  input  wire logic [STRIDE_W-1:0]   cfg_wdata
);

  localparam int ENTRY_W = 1 + 3 * COORD_BITS + 2 + (COORD_BITS + 4)
                           + 2 * (COORD_BITS + 2) + OFF_W;
  localparam int Q_DEPTH = 2;

  logic [STRIDE_W-1:0] row_stride_r;
  logic [ENTRY_W-1:0]  fr_entry;
  logic [ENTRY_W-1:0]  q_data;
  logic                q_full, q_empty;
  logic                in_xfer;
  bk_stat_t            bk_stat;

  // Row stride register; the user must write it only while no line is in flight (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= STRIDE_RESET;
    end else if (cfg_we) begin
      row_stride_r <= cfg_wdata;
    end
  end

  // Hold the command channel only when the queue is full
  assign in_stall = q_full;
  assign in_xfer  = in_valid && !in_stall;

  // Front end: order the endpoints, classify the octant, seed the decision
  // value and the row part of the first byte offset
  lrast_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .command    (in_command),
    .start_x    (in_start_x),
    .start_y    (in_start_y),
    .end_x      (in_end_x),
    .end_y      (in_end_y),
    .row_stride (row_stride_r),
    .entry      (fr_entry)
  );

  // Short queue decouples acceptance from pixel output backpressure
  lrast_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_data (fr_entry),
    .pop       (bk_stat.pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: load lines, advance one pixel per step, drop steps while idle
  lrast_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (q_data),
    .q_empty     (q_empty),
    .row_stride  (row_stride_r),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .pixel_x     (out_pixel_x),
    .pixel_y     (out_pixel_y),
    .byte_offset (out_byte_offset),
    .last_pixel  (out_last_pixel),
    .stat        (bk_stat)
  );

  // The engine never pulls from an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !bk_stat.pop)
    else $error("pixel engine popped an empty command queue");

  // A step that reaches an idle engine produces no pixel
  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.pop && (q_data[ENTRY_W-1] == CMD_STEP) && !bk_stat.active)
      |=> !out_valid)
    else $error("step on idle engine produced a pixel");

  // A start into an empty, idle path shows its first pixel once through the queue and the engine state
  a_start_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_command == CMD_START) && q_empty && !out_valid)
      |-> ##2 out_valid)
    else $error("start command did not produce its first pixel on time");

endmodule

`default_nettype wire

// File: sim/midpoint_line_rasterizer_unit_tb.sv
module midpoint_line_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lrast_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int PIXEL_BYTES = 1 << PIXEL_SHIFT;
  // Padding after the last owed pixel so nothing is still in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_REPORTS   = 50;

  // Receiver stall behaviors, switched at random intervals.
  typedef enum logic [1:0] {
    STALL_NONE     = 2'd0,
    STALL_LIGHT    = 2'd1,
    STALL_HEAVY    = 2'd2,
    STALL_PERIODIC = 2'd3
  } stall_mode_t;

  typedef struct {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [OFF_W-1:0]      offset;
    logic                  last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_command = CMD_START;
  logic [COORD_BITS-1:0] in_start_x = '0;
  logic [COORD_BITS-1:0] in_start_y = '0;
  logic [COORD_BITS-1:0] in_end_x = '0;
  logic [COORD_BITS-1:0] in_end_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_BITS-1:0] out_pixel_x;
  logic [COORD_BITS-1:0] out_pixel_y;
  logic [OFF_W-1:0]      out_byte_offset;
  logic                  out_last_pixel;
  logic                  cfg_we = 1'b0;
  logic [STRIDE_W-1:0]   cfg_wdata = '0;

  // Pixels the block owes us, oldest first.
  pixel_t pixel_q[$];

  // Shadow copy of the rasterizer state.
  logic [COORD_BITS-1:0] ln_x, ln_y, ln_major_end;
  logic [OFF_W-1:0]      ln_offset;
  int                    ln_decision, ln_step_a2, ln_step_b2;
  line_class_t           ln_class;
  bit                    ln_active;
  logic [STRIDE_W-1:0]   row_stride;

  int          mismatches = 0;
  int          n_items = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  midpoint_line_rasterizer_unit #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_byte_offset(out_byte_offset),
    .out_last_pixel (out_last_pixel),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Advance the shadow rasterizer by one command and queue the pixel it emits.
  task automatic trace_command(input logic cmd, input logic [COORD_BITS-1:0] sx,
                               input logic [COORD_BITS-1:0] sy,
                               input logic [COORD_BITS-1:0] ex,
                               input logic [COORD_BITS-1:0] ey);
    int x0, y0, x1, y1, dx, dy, tmp, a, b;
    bit shallow;
    logic [COORD_BITS-1:0] major;
    pixel_t pix;
    if (cmd == CMD_START) begin
      x0 = sx;
      y0 = sy;
      x1 = ex;
      y1 = ey;
      dx = x1 - x0;
      dy = y1 - y0;
      // A diagonal (equal spans) is handled as steep.
      shallow = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy);
      // Order the endpoints so the major axis counts up.
      if (shallow ? (x0 > x1) : (y0 > y1)) begin
        tmp = x0; x0 = x1; x1 = tmp;
        tmp = y0; y0 = y1; y1 = tmp;
      end
      a = y0 - y1;
      b = x1 - x0;
      if (shallow) begin
        if (y0 > y1) begin
          ln_class    = CLS_SHALLOW_FALL;
          ln_decision = 2 * a - b;
        end else begin
          ln_class    = CLS_SHALLOW_RISE;
          ln_decision = 2 * a + b;
        end
        ln_major_end = COORD_BITS'(x1);
      end else begin
        if (x1 > x0) begin
          ln_class    = CLS_STEEP_RIGHT;
          ln_decision = a + 2 * b;
        end else begin
          ln_class    = CLS_STEEP_LEFT;
          ln_decision = -a + 2 * b;
        end
        ln_major_end = COORD_BITS'(y1);
      end
      ln_step_a2 = 2 * a;
      ln_step_b2 = 2 * b;
      ln_x       = COORD_BITS'(x0);
      ln_y       = COORD_BITS'(y0);
      ln_offset  = OFF_W'(x0 * PIXEL_BYTES + y0 * int'(row_stride));
    end else begin
      // A step with no line in progress produces nothing.
      if (!ln_active) return;
      case (ln_class)
        CLS_SHALLOW_FALL: begin
          if (ln_decision > 0) begin
            ln_decision -= ln_step_b2;
            ln_y      = ln_y - 1'b1;
            ln_offset = ln_offset - row_stride;
          end
          ln_x      = ln_x + 1'b1;
          ln_offset = ln_offset + PIXEL_BYTES;
          ln_decision += ln_step_a2;
        end
        CLS_SHALLOW_RISE: begin
          if (ln_decision < 0) begin
            ln_decision += ln_step_b2;
            ln_y      = ln_y + 1'b1;
            ln_offset = ln_offset + row_stride;
          end
          ln_x      = ln_x + 1'b1;
          ln_offset = ln_offset + PIXEL_BYTES;
          ln_decision += ln_step_a2;
        end
        CLS_STEEP_RIGHT: begin
          if (ln_decision > 0) begin
            ln_decision += ln_step_a2;
            ln_x      = ln_x + 1'b1;
            ln_offset = ln_offset + PIXEL_BYTES;
          end
          ln_y      = ln_y + 1'b1;
          ln_offset = ln_offset + row_stride;
          ln_decision += ln_step_b2;
        end
        default: begin
          if (ln_decision < 0) begin
            ln_decision -= ln_step_a2;
            ln_x      = ln_x - 1'b1;
            ln_offset = ln_offset - PIXEL_BYTES;
          end
          ln_y      = ln_y + 1'b1;
          ln_offset = ln_offset + row_stride;
          ln_decision += ln_step_b2;
        end
      endcase
    end
    major = (ln_class == CLS_SHALLOW_FALL || ln_class == CLS_SHALLOW_RISE) ? ln_x : ln_y;
    pix.x      = ln_x;
    pix.y      = ln_y;
    pix.offset = ln_offset;
    pix.last   = (major == ln_major_end);
    ln_active  = !pix.last;
    pixel_q.push_back(pix);
  endtask

  // Present one command, hold it until the block takes it, then maybe open a gap.
  task automatic send_command(input logic cmd, input logic [COORD_BITS-1:0] sx,
                              input logic [COORD_BITS-1:0] sy,
                              input logic [COORD_BITS-1:0] ex,
                              input logic [COORD_BITS-1:0] ey);
    int gap;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x   <= ex;
    in_end_y   <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Idle steps are ignored by the block and do not count as work.
    if (cmd == CMD_START || ln_active) n_items++;
    trace_command(cmd, sx, sy, ex, ey);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Mostly short bursts; now and then a long stretch with no gaps at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_step();
    send_command(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                 COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  // Step the current line until it ends or the step budget runs out.
  task automatic finish_line(input int max_steps);
    int k;
    k = 0;
    while (ln_active && k < max_steps) begin
      send_step();
      k++;
    end
  endtask

  task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                           input int max_steps);
    send_command(CMD_START, COORD_BITS'(sx), COORD_BITS'(sy),
                 COORD_BITS'(ex), COORD_BITS'(ey));
    finish_line(max_steps);
  endtask

  // Hold off the sender until every owed pixel is back and the pipe is empty.
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stride(input logic [STRIDE_W-1:0] value);
    settle_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    row_stride = value;
  endtask

  function automatic logic [STRIDE_W-1:0] pick_stride();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return STRIDE_RESET;
      default: return STRIDE_W'($urandom);
    endcase
  endfunction

  // Anywhere on the grid, with the borders favored.
  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic int near_coord(input int c, input int span);
    int lo, hi;
    lo = (c - span < 0) ? 0 : c - span;
    hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
    return $urandom_range(lo, hi);
  endfunction

  // Steps with no line, each followed by a single-pixel line from equal endpoints.
  task automatic test_idle_commands();
    send_step();
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 4);
    send_step();
    draw_line(0, 0, 0, 0, 4);
  endtask

  // At least one short line per octant class, including a diagonal and a vertical.
  task automatic test_line_classes();
    draw_line(5, 6, 2, 8, 8);                                  // shallow falling, swapped
    draw_line(COORD_MAX, 0, COORD_MAX - 3, 0, 8);              // level, swapped
    draw_line(0, COORD_MAX - 2, 1, COORD_MAX, 8);              // steep right
    draw_line(3, 0, 1, 2, 8);                                  // diagonal counts as steep left
    draw_line(7, 9, 7, 7, 8);                                  // vertical, swapped
  endtask

  // A new start drops the line in progress.
  task automatic test_restart();
    draw_line(0, 0, COORD_MAX, COORD_MAX, 2);
    draw_line(COORD_MAX, 0, 0, COORD_MAX, 1);
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 1, 4);
  endtask

  // Stride extremes, and a stride change under a live line that wraps the offset.
  task automatic test_stride();
    write_stride('0);
    draw_line(0, 3, 6, 0, 0);
    write_stride('1);
    finish_line(8);
    draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX, 4);
  endtask

  task automatic test_random_lines();
    int kind, span, sx, sy;
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) write_stride(pick_stride());
      kind = $urandom_range(0, 19);
      sx   = rand_coord();
      sy   = rand_coord();
      span = $urandom_range(0, 24);
      case (kind)
        0: send_step();
        1: draw_line(sx, sy, rand_coord(), rand_coord(), $urandom_range(20, 300));
        2, 3: draw_line(sx, sy, near_coord(sx, span), near_coord(sy, span),
                        $urandom_range(0, span));
        4: begin
          // Change the stride under whatever line is still live, then finish it.
          write_stride(pick_stride());
          finish_line(400);
        end
        default: draw_line(sx, sy, near_coord(sx, span), near_coord(sy, span), 4 * COORD_MAX);
      endcase
    end
  endtask

  // Receiver back-pressure: each mode holds for a random stretch.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_left[2];
    endcase
  end

  // Compare each pixel transaction against the oldest owed pixel.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d)", out_pixel_x, out_pixel_y));
      end else begin
        want = pixel_q.pop_front();
        if (out_pixel_x !== want.x)
          report_mismatch($sformatf("pixel_x got %0d want %0d", out_pixel_x, want.x));
        if (out_pixel_y !== want.y)
          report_mismatch($sformatf("pixel_y got %0d want %0d", out_pixel_y, want.y));
        if (out_byte_offset !== want.offset)
          report_mismatch($sformatf("byte_offset got %0d want %0d",
                                    out_byte_offset, want.offset));
        if (out_last_pixel !== want.last)
          report_mismatch($sformatf("last_pixel got %0b want %0b",
                                    out_last_pixel, want.last));
      end
    end
  end

  initial begin
    row_stride  = STRIDE_RESET;
    ln_x        = '0;
    ln_y        = '0;
    ln_major_end = '0;
    ln_offset   = '0;
    ln_decision = 0;
    ln_step_a2  = 0;
    ln_step_b2  = 0;
    ln_class    = CLS_SHALLOW_FALL;
    ln_active   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_commands();
    test_line_classes();
    test_restart();
    test_stride();
    test_random_lines();

    settle_pipeline();
    if (mismatches == 0) begin
      $display("midpoint_line_rasterizer_unit_tb: PASS");
    end else begin
      $display("midpoint_line_rasterizer_unit_tb: FAIL");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legitimate run.
  initial begin
    #2_000_000;
    $display("midpoint_line_rasterizer_unit_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lrast_pkg.sv
hw/rtl/lrast_fifo.sv
hw/rtl/lrast_front.sv
hw/rtl/lrast_back.sv
hw/rtl/midpoint_line_rasterizer_unit.sv
sim/midpoint_line_rasterizer_unit_tb.sv
